// ----- design/ihfp_pkg.sv -----
// Shared constants and types for the image header format probe.
package ihfp_pkg;

  localparam int HDR_DEPTH  = 26;
  localparam int WIN_DEPTH  = 10;
  localparam int WALK_STEPS = 3;

  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DEFAULT_WIDTH    = 2'd0;
  localparam logic [1:0] REG_DEFAULT_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_DEFAULT_CHANNELS = 2'd2;

  // JPEG markers
  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_SOF0   = 8'hC0;
  localparam logic [7:0] MARK_SOF2   = 8'hC2;

  // Header tags
  localparam logic [0:7][7:0] PNG_SIG  = {8'h89, 8'h50, 8'h4E, 8'h47,
                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};
  localparam logic [0:3][7:0] SIMR_TAG = {8'h53, 8'h49, 8'h4D, 8'h52};
  localparam logic [7:0] TIFF_INTEL    = 8'h49;
  localparam logic [7:0] TIFF_MOTOROLA = 8'h4D;

  // PNG colour types
  localparam logic [7:0] PNG_CT_GRAY    = 8'd0;
  localparam logic [7:0] PNG_CT_RGB     = 8'd2;
  localparam logic [7:0] PNG_CT_PALETTE = 8'd3;
  localparam logic [7:0] PNG_CT_GRAYA   = 8'd4;
  localparam logic [7:0] PNG_CT_RGBA    = 8'd6;

  typedef enum logic [1:0] {
    FMT_RAW_U8,
    FMT_JPG,
    FMT_PNG,
    FMT_TIFF
  } format_t;

  typedef enum logic [2:0] {
    COLOR_GRAY,
    COLOR_RGB,
    COLOR_GRAYA,
    COLOR_RGBA,
    COLOR_BGRA
  } color_t;

endpackage

// ----- design/ihfp_in_if.sv -----
// Byte stream channel into the image header format probe.
interface ihfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, data_byte, end_of_buffer, input ready);
  modport sink   (input valid, data_byte, end_of_buffer, output ready);
endinterface

// ----- design/ihfp_out_if.sv -----
// Result channel out of the image header format probe.
interface ihfp_out_if;
  logic              valid;
  logic              ready;
  ihfp_pkg::format_t format_kind;
  logic              compressed;
  logic [31:0]       image_width;
  logic [31:0]       image_height;
  logic [7:0]        channel_count;
  ihfp_pkg::color_t  color_code;

  modport source (output valid, format_kind, compressed, image_width, image_height,
                  channel_count, color_code, input ready);
  modport sink   (input valid, format_kind, compressed, image_width, image_height,
                  channel_count, color_code, output ready);
endinterface

// ----- design/image_header_format_probe.sv -----
// Top level of the image header format probe: byte walker, format decode, result register.
//
// Usage:
//   in_bus carries an image buffer one word (byte) per handshake; end_of_buffer
//   marks the final byte. Every buffer yields exactly one result word on out_bus:
//   format, encoded flag, width, height, channel count and colour code.
//   The probe tries a SIMR raw header, then JPEG (the marker walker follows the
//   segments from byte 2 to the first SOF0/SOF2), PNG, TIFF, else raw with the defaults.
//   Throughput: one byte per cycle unless the output stalls, set by the single-pass
//   marker walker that resolves up to three cursor moves per byte within the cycle.
//   Result: the word appears in the output register in the cycle after the
//   final byte is accepted.
//   Stall: the output register holds its word until out_bus.ready; while it is
//   full and not being taken, in_bus.ready drops and input bytes wait.
//   Reset: rst_n (synchronous, active low) clears the walker, the byte count,
//   the output valid and the three default registers. No clearing pass.
//   Config: APB-style writes at byte addresses 0 (default_width), 4
//   (default_height) and 8 (default_channels); pready is tied high.
//   After each result the byte count, window and walker return to their start values.
module image_header_format_probe #(
  parameter int POSITION_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  ihfp_in_if.sink                              in_bus,
  ihfp_out_if.source                           out_bus,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ihfp_pkg::CFG_ADDR_BITS-1:0]   cfg_paddr,
  input  logic [ihfp_pkg::CFG_DATA_BITS-1:0]   cfg_pwdata,
  output logic [ihfp_pkg::CFG_DATA_BITS-1:0]   cfg_prdata,
  output logic                                 cfg_pready
);

  localparam int LAG_BITS = $clog2(ihfp_pkg::WIN_DEPTH);
  localparam logic [LAG_BITS-1:0] LAG_MAX = LAG_BITS'(ihfp_pkg::WIN_DEPTH - 1);
  // Offsets behind an SOF marker prefix: the component byte is the farthest
  localparam int SOF_SPAN   = 9;
  localparam int LEN_SPAN   = 3;
  localparam int SKIP_BITS  = 17;
  localparam logic [SKIP_BITS-1:0] SKIP_START = SKIP_BITS'(2);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_WALK,
    PH_DONE
  } phase_t;

  typedef logic [ihfp_pkg::WIN_DEPTH-1:0][7:0] window_t;

  typedef struct packed {
    phase_t                 phase;
    logic [LAG_BITS-1:0]    lag;
    logic [SKIP_BITS-1:0]   skip;
    logic                   sof_seen;
    logic [15:0]            sof_height;
    logic [15:0]            sof_width;
    logic [7:0]             sof_components;
  } walk_t;

  // One cursor move of the marker walker; a blocked cursor leaves the state alone,
  // so repeating the step on a blocked state is harmless.
  function automatic walk_t walk_step(input walk_t s, input window_t w);
    walk_t                r;
    logic [7:0]           mark;
    logic [SKIP_BITS-1:0] adv;
    logic                 move;
    r    = s;
    mark = '0;
    adv  = '0;
    move = 1'b0;
    if (s.phase == PH_WALK) begin
      if (w[s.lag] != ihfp_pkg::MARK_PREFIX) begin
        adv  = SKIP_BITS'(1);
        move = 1'b1;
      end else if (s.lag != '0) begin
        mark = w[s.lag - LAG_BITS'(1)];
        if (mark == ihfp_pkg::MARK_SOF0 || mark == ihfp_pkg::MARK_SOF2) begin
          if (s.lag >= LAG_BITS'(SOF_SPAN)) begin
            r.sof_height     = {w[s.lag - LAG_BITS'(5)], w[s.lag - LAG_BITS'(6)]};
            r.sof_width      = {w[s.lag - LAG_BITS'(7)], w[s.lag - LAG_BITS'(8)]};
            r.sof_components = w[s.lag - LAG_BITS'(SOF_SPAN)];
            r.sof_seen       = 1'b1;
            r.phase          = PH_DONE;
          end
        end else if (s.lag >= LAG_BITS'(LEN_SPAN)) begin
          adv  = SKIP_BITS'(2) + {1'b0, w[s.lag - LAG_BITS'(2)], w[s.lag - LAG_BITS'(3)]};
          move = 1'b1;
        end
      end
      if (move) begin
        if (adv <= SKIP_BITS'(s.lag)) begin
          r.lag = s.lag - adv[LAG_BITS-1:0];
        end else begin
          // Segment runs past the window: count the rest down as bytes arrive
          r.phase = PH_SKIP;
          r.skip  = adv - SKIP_BITS'(s.lag) - SKIP_BITS'(1);
          r.lag   = '0;
        end
      end
    end
    return r;
  endfunction

  // Registers
  logic [15:0]              def_width_r;
  logic [15:0]              def_height_r;
  logic [7:0]               def_channels_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [7:0]               header_r [ihfp_pkg::HDR_DEPTH];
  window_t                  window_r;
  walk_t                    walk_r;
  logic                     out_valid_r;
  ihfp_pkg::format_t        fmt_r;
  logic                     enc_r;
  logic [31:0]              width_r;
  logic [31:0]              height_r;
  logic [7:0]               chan_r;
  ihfp_pkg::color_t         color_r;

  // Next values
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [7:0]               header_nxt [ihfp_pkg::HDR_DEPTH];
  window_t                  window_nxt;
  walk_t                    walk_pre;
  walk_t                    walk_nxt;
  ihfp_pkg::format_t        fmt_nxt;
  logic                     enc_nxt;
  logic [31:0]              width_nxt;
  logic [31:0]              height_nxt;
  logic [7:0]               chan_nxt;
  ihfp_pkg::color_t         color_nxt;

  logic       in_ready;
  logic       in_take;
  logic       in_last;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic       png_match;
  logic       simr_match;
  logic [7:0] png_ct;

  assign in_ready     = !out_valid_r || out_bus.ready;
  assign in_bus.ready = in_ready;
  assign in_take      = in_bus.valid && in_ready;
  assign in_last      = in_take && in_bus.end_of_buffer;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_index  = cfg_paddr[ihfp_pkg::CFG_ADDR_BITS-1:2];

  always_comb begin
    case (cfg_index)
      ihfp_pkg::REG_DEFAULT_WIDTH:
        cfg_prdata = ihfp_pkg::CFG_DATA_BITS'(def_width_r);
      ihfp_pkg::REG_DEFAULT_HEIGHT:
        cfg_prdata = ihfp_pkg::CFG_DATA_BITS'(def_height_r);
      ihfp_pkg::REG_DEFAULT_CHANNELS:
        cfg_prdata = ihfp_pkg::CFG_DATA_BITS'(def_channels_r);
      default:
        cfg_prdata = '0;
    endcase
  end

  // Byte count, header capture and window shift
  always_comb begin
    pos_nxt = (pos_r == '1) ? pos_r : pos_r + POSITION_BITS'(1);
    for (int k = 0; k < ihfp_pkg::HDR_DEPTH; k++) begin
      header_nxt[k] = (pos_r == POSITION_BITS'(k)) ? in_bus.data_byte : header_r[k];
    end
    window_nxt = {window_r[ihfp_pkg::WIN_DEPTH-2:0], in_bus.data_byte};
  end

  // Marker walker: advance the skip count or the cursor lag, then resolve moves
  always_comb begin
    walk_pre = walk_r;
    case (walk_r.phase)
      PH_SKIP: begin
        if (walk_r.skip == '0) begin
          walk_pre.phase = PH_WALK;
          walk_pre.lag   = '0;
        end else begin
          walk_pre.skip = walk_r.skip - SKIP_BITS'(1);
        end
      end
      PH_WALK: begin
        if (walk_r.lag < LAG_MAX) walk_pre.lag = walk_r.lag + LAG_BITS'(1);
      end
      default: ;
    endcase
    walk_nxt = walk_pre;
    for (int i = 0; i < ihfp_pkg::WALK_STEPS; i++) begin
      walk_nxt = walk_step(walk_nxt, window_nxt);
    end
  end

  // Format decode on the buffer as it stands after this byte
  always_comb begin
    simr_match = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (header_nxt[k] != ihfp_pkg::SIMR_TAG[k]) simr_match = 1'b0;
    end
    png_match = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (header_nxt[k] != ihfp_pkg::PNG_SIG[k]) png_match = 1'b0;
    end
    png_ct = (pos_nxt > POSITION_BITS'(25)) ? header_nxt[25] : ihfp_pkg::PNG_CT_RGBA;

    fmt_nxt    = ihfp_pkg::FMT_RAW_U8;
    enc_nxt    = 1'b0;
    width_nxt  = 32'(def_width_r);
    height_nxt = 32'(def_height_r);
    chan_nxt   = (def_channels_r != '0) ? def_channels_r : 8'd4;
    color_nxt  = (chan_nxt == 8'd4) ? ihfp_pkg::COLOR_BGRA : ihfp_pkg::COLOR_RGB;

    if (pos_nxt >= POSITION_BITS'(24) && simr_match) begin
      width_nxt  = {header_nxt[19], header_nxt[18], header_nxt[17], header_nxt[16]};
      height_nxt = {header_nxt[23], header_nxt[22], header_nxt[21], header_nxt[20]};
      chan_nxt   = 8'd3;
      color_nxt  = ihfp_pkg::COLOR_RGB;
    end else if (pos_nxt >= POSITION_BITS'(4) && header_nxt[0] == ihfp_pkg::MARK_PREFIX &&
                 header_nxt[1] == ihfp_pkg::MARK_SOI) begin
      fmt_nxt = ihfp_pkg::FMT_JPG;
      enc_nxt = 1'b1;
      if (walk_nxt.sof_seen) begin
        width_nxt  = 32'(walk_nxt.sof_width);
        height_nxt = 32'(walk_nxt.sof_height);
        chan_nxt   = walk_nxt.sof_components;
      end else begin
        chan_nxt = (def_channels_r != '0) ? def_channels_r : 8'd3;
      end
      color_nxt = (chan_nxt == 8'd1) ? ihfp_pkg::COLOR_GRAY : ihfp_pkg::COLOR_RGB;
    end else if (pos_nxt >= POSITION_BITS'(24) && png_match) begin
      fmt_nxt    = ihfp_pkg::FMT_PNG;
      enc_nxt    = 1'b1;
      width_nxt  = {header_nxt[16], header_nxt[17], header_nxt[18], header_nxt[19]};
      height_nxt = {header_nxt[20], header_nxt[21], header_nxt[22], header_nxt[23]};
      case (png_ct)
        ihfp_pkg::PNG_CT_GRAY: begin
          chan_nxt  = 8'd1;
          color_nxt = ihfp_pkg::COLOR_GRAY;
        end
        ihfp_pkg::PNG_CT_RGB: begin
          chan_nxt  = 8'd3;
          color_nxt = ihfp_pkg::COLOR_RGB;
        end
        ihfp_pkg::PNG_CT_PALETTE: begin
          chan_nxt  = 8'd1;
          color_nxt = ihfp_pkg::COLOR_GRAY;
        end
        ihfp_pkg::PNG_CT_GRAYA: begin
          chan_nxt  = 8'd2;
          color_nxt = ihfp_pkg::COLOR_GRAYA;
        end
        default: begin
          chan_nxt  = 8'd4;
          color_nxt = ihfp_pkg::COLOR_RGBA;
        end
      endcase
    end else if (pos_nxt >= POSITION_BITS'(4) &&
                 ((header_nxt[0] == ihfp_pkg::TIFF_INTEL &&
                   header_nxt[1] == ihfp_pkg::TIFF_INTEL) ||
                  (header_nxt[0] == ihfp_pkg::TIFF_MOTOROLA &&
                   header_nxt[1] == ihfp_pkg::TIFF_MOTOROLA))) begin
      fmt_nxt   = ihfp_pkg::FMT_TIFF;
      enc_nxt   = 1'b1;
      chan_nxt  = (def_channels_r != '0) ? def_channels_r : 8'd3;
      color_nxt = ihfp_pkg::COLOR_RGB;
    end
  end

  // Control state: defaults, walker, byte count, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_width_r             <= '0;
      def_height_r            <= '0;
      def_channels_r          <= '0;
      pos_r                   <= '0;
      window_r                <= '0;
      walk_r.phase            <= PH_SKIP;
      walk_r.lag              <= '0;
      walk_r.skip             <= SKIP_START;
      walk_r.sof_seen         <= 1'b0;
      walk_r.sof_height       <= '0;
      walk_r.sof_width        <= '0;
      walk_r.sof_components   <= '0;
      out_valid_r             <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          ihfp_pkg::REG_DEFAULT_WIDTH:    def_width_r    <= cfg_pwdata[15:0];
          ihfp_pkg::REG_DEFAULT_HEIGHT:   def_height_r   <= cfg_pwdata[15:0];
          ihfp_pkg::REG_DEFAULT_CHANNELS: def_channels_r <= cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_take) begin
        if (in_bus.end_of_buffer) begin
          // Restart the byte count, window and walker for the next buffer
          pos_r                 <= '0;
          window_r              <= '0;
          walk_r.phase          <= PH_SKIP;
          walk_r.lag            <= '0;
          walk_r.skip           <= SKIP_START;
          walk_r.sof_seen       <= 1'b0;
          walk_r.sof_height     <= '0;
          walk_r.sof_width      <= '0;
          walk_r.sof_components <= '0;
        end else begin
          pos_r    <= pos_nxt;
          window_r <= window_nxt;
          walk_r   <= walk_nxt;
        end
      end
      if (in_last) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload: header bytes and result word, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      for (int k = 0; k < ihfp_pkg::HDR_DEPTH; k++) header_r[k] <= header_nxt[k];
    end
    if (in_last) begin
      fmt_r    <= fmt_nxt;
      enc_r    <= enc_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      chan_r   <= chan_nxt;
      color_r  <= color_nxt;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.format_kind   = fmt_r;
  assign out_bus.compressed    = enc_r;
  assign out_bus.image_width   = width_r;
  assign out_bus.image_height  = height_r;
  assign out_bus.channel_count = chan_r;
  assign out_bus.color_code    = color_r;

  // The walker finishes exactly when it has captured an SOF
  a_done_has_sof: assert property (@(posedge clk) disable iff (!rst_n)
    (walk_r.phase == PH_DONE) == walk_r.sof_seen)
    else $error("walker done flag and SOF capture disagree");

  a_skip_lag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r.phase == PH_SKIP |-> walk_r.lag == '0)
    else $error("cursor lag not cleared while skipping");

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    walk_r.lag <= LAG_MAX)
    else $error("cursor lag beyond the window");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_last |=> out_valid_r && pos_r == '0 && walk_r.phase == PH_SKIP)
    else $error("final byte did not post a result and restart the buffer");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |-> !in_take)
    else $error("byte taken while the result register is blocked");

endmodule
